>>> src/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg
// shared types, register indexes and the quadrature transition table
// ----------------------------------------------------------------------------
package qdd_pkg;

  localparam int CfgIdxW = 2;
  localparam int CpdW    = 4;
  localparam int DebW    = 20;
  localparam int TimeW   = 32;
  localparam int SumW    = 5;

  localparam logic [CfgIdxW-1:0] REG_COUNTS_PER_DETENT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TIME_US  = 2'd1;

  localparam logic [CpdW-1:0]  CPD_RESET      = 4'd4;
  localparam logic [DebW-1:0]  DEB_RESET      = 20'd20000;
  localparam logic [1:0]       LINES_IDLE     = 2'b11;

  localparam logic signed [1:0] STEP_NONE = 2'sd0;
  localparam logic signed [1:0] STEP_CW   = 2'sd1;
  localparam logic signed [1:0] STEP_CCW  = -2'sd1;

  typedef struct packed {
    logic             line_a;
    logic             line_b;
    logic             switch_rise;
    logic [TimeW-1:0] time_us;
  } qdd_in_t;

  typedef struct packed {
    logic signed [1:0] step;
    logic              sw_release;
  } qdd_out_t;

  typedef struct packed {
    logic [CpdW-1:0] counts_per_detent;
    logic [DebW-1:0] debounce_time_us;
  } qdd_cfg_t;

  // index is {previous a, previous b, current a, current b}
  function automatic logic signed [1:0] qdd_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = STEP_CCW;
      4'd2, 4'd4, 4'd11, 4'd13: d = STEP_CW;
      default:                  d = STEP_NONE;
    endcase
    return d;
  endfunction

endpackage

>>> src/quadrature_detent_decoder_unit.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_unit
// quadrature encoder detent decoder with debounced push-switch release
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_valid / in_stall    qdd_in_t  (line_a, line_b, switch_rise, time_us)
//  out_     out  out_valid / out_stall  qdd_out_t (step, sw_release)
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one item per cycle while out_stall stays low; an item passes the input register then
//  result register, with table lookup, sum, compare and time subtract between
//  reset is synchronous on rst_n low: both pipeline stages empty, lines idle high,
//  sum and last release time zero, registers at their defaults
//  out_stall holds the result register; the input register keeps taking items
//  until it is also full, so in_stall rises only with both stages occupied
// ----------------------------------------------------------------------------
module quadrature_detent_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qdd_pkg::qdd_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qdd_pkg::qdd_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qdd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [qdd_pkg::DebW-1:0]      cfg_data
);
  import qdd_pkg::*;

  // input register stage
  logic     s1_valid_r;
  qdd_in_t  s1_data_r;
  // result register stage
  logic     out_valid_r;
  qdd_out_t out_data_r;
  // configuration registers
  qdd_cfg_t cfg_r;

  logic              out_free;
  logic              fire;
  logic              in_take;
  logic signed [1:0] res_step;
  logic              res_release;
  qdd_out_t          res;

  // result register can take a new item when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  // an item moves from the input register through the datapath
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  qdd_rot u_rot (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (fire),
    .line_a            (s1_data_r.line_a),
    .line_b            (s1_data_r.line_b),
    .counts_per_detent (cfg_r.counts_per_detent),
    .step              (res_step)
  );

  qdd_btn u_btn (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .switch_rise      (s1_data_r.switch_rise),
    .time_us          (s1_data_r.time_us),
    .debounce_time_us (cfg_r.debounce_time_us),
    .released         (res_release)
  );

  assign res = '{step: res_step, sw_release: res_release};

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counts_per_detent <= CPD_RESET;
      cfg_r.debounce_time_us  <= DEB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COUNTS_PER_DETENT: cfg_r.counts_per_detent <= cfg_data[CpdW-1:0];
        REG_DEBOUNCE_TIME_US:  cfg_r.debounce_time_us  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a shown step is never the unused code
  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.step != 2'b10))
    else $error("step holds unused code");

  // in_stall only with both stages occupied and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // a processed item always lands in the result register
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item lost");

  // pipeline empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

>>> src/qdd_rot.sv
// ----------------------------------------------------------------------------
// qdd_rot
// quadrature transition accumulator and detent step detector
// ----------------------------------------------------------------------------
module qdd_rot (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic                          line_a,
  input  logic                          line_b,
  input  logic [qdd_pkg::CpdW-1:0]      counts_per_detent,
  output logic signed [1:0]             step
);
  import qdd_pkg::*;

  logic [1:0]             prev_lines_r, prev_lines_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [1:0]             cur;
  logic signed [SumW-1:0] sum_add;
  logic signed [SumW-1:0] limit;

  assign cur     = {line_a, line_b};
  assign sum_add = sum_r + SumW'(qdd_delta({prev_lines_r, cur}));
  // zero acts as one
  assign limit   = (counts_per_detent == '0) ? SumW'(1)
                                             : $signed({1'b0, counts_per_detent});

  always_comb begin
    step           = STEP_NONE;
    sum_nxt        = sum_add;
    prev_lines_nxt = cur;
    if (sum_add >= limit) begin
      step    = STEP_CW;
      sum_nxt = '0;
    end else if (sum_add <= -limit) begin
      step    = STEP_CCW;
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lines_r <= LINES_IDLE;
      sum_r        <= '0;
    end else if (fire) begin
      prev_lines_r <= prev_lines_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

>>> src/qdd_btn.sv
// ----------------------------------------------------------------------------
// qdd_btn
// push-switch release debounce against the last accepted release time
// ----------------------------------------------------------------------------
module qdd_btn (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic                       switch_rise,
  input  logic [qdd_pkg::TimeW-1:0]  time_us,
  input  logic [qdd_pkg::DebW-1:0]   debounce_time_us,
  output logic                       released
);
  import qdd_pkg::*;

  logic [TimeW-1:0] last_rel_r;
  logic [TimeW-1:0] elapsed;

  // wrapping difference
  assign elapsed  = time_us - last_rel_r;
  assign released = switch_rise && (elapsed >= TimeW'(debounce_time_us));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rel_r <= '0;
    end else if (fire && released) begin
      last_rel_r <= time_us;
    end
  end

endmodule
